// ===== src/quadratic_outline_to_path_commands_macros.svh =====
// assertion macros for the outline to path command block
`ifndef QUADRATIC_OUTLINE_TO_PATH_COMMANDS_MACROS_SVH
`define QUADRATIC_OUTLINE_TO_PATH_COMMANDS_MACROS_SVH

`ifndef NO_ASSERTIONS
`define QOPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define QOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define QOPC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define QOPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/qopc_pkg.sv =====
package qopc_pkg;

    localparam int COORD_BITS  = 24;
    localparam int IN_W        = 24;
    localparam int OUT_W       = 28;
    localparam int QUEUE_DEPTH = 4;
    localparam int WIDE_W      = 64;
    localparam int SCALE_W     = 40;
    localparam int MID_SHIFT   = 3;

    // coordinate slots of one job, all held as twice the raw value
    localparam int JOB_COORDS = 8;
    localparam int J_AX = 0;
    localparam int J_AY = 1;
    localparam int J_BX = 2;
    localparam int J_BY = 3;
    localparam int J_CX = 4;
    localparam int J_CY = 5;
    localparam int J_SX = 6;
    localparam int J_SY = 7;

    typedef enum logic [1:0] {
        CMD_END  = 2'd0,
        CMD_MOVE = 2'd1,
        CMD_LINE = 2'd2,
        CMD_QUAD = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        PH_PRIM  = 3'b001,
        PH_CLOSE = 3'b010,
        PH_END   = 3'b100
    } t_phase;

    typedef struct packed {
        logic signed [IN_W-1:0] point_x;
        logic signed [IN_W-1:0] point_y;
        logic                   on_curve;
        logic                   contour_end;
    } t_in;

    typedef struct packed {
        t_cmd                    command;
        logic signed [OUT_W-1:0] first_x;
        logic signed [OUT_W-1:0] first_y;
        logic signed [OUT_W-1:0] end_x;
        logic signed [OUT_W-1:0] end_y;
        logic                    last_of_run;
    } t_out;

    typedef struct packed {
        logic has_prim;
        t_cmd prim_cmd;
        logic has_close;
        logic close_quad;
    } t_job_ctl;

endpackage

// ===== src/quadratic_outline_to_path_commands.sv =====
// Turns a stream of outline points into move, line, quadratic and end commands in signed 24.4.
// A point is taken in every cycle that push is high and full is low; the front classifies it against the
// held contour start and control point in the same cycle and queues one job of one to three
// results in a QUEUE_DEPTH-entry job queue, or nothing for a control point that is only held.
// The back sends one result per cycle through its output register while it is empty or popped;
// so a point's first result reaches the result ports through the job queue and that register,
// and a contour end, which gives up to three results, holds the back until they are all sent;
// the job queue absorbs that, and full rises only when it is filled.
`include "quadratic_outline_to_path_commands_macros.svh"

module quadratic_outline_to_path_commands #(
    parameter int COORD_BITS  = qopc_pkg::COORD_BITS,
    parameter int QUEUE_DEPTH = qopc_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  qopc_pkg::t_in  i_item,
    input  logic           push,
    output logic           full,
    output qopc_pkg::t_out o_result,
    output logic           empty,
    input  logic           pop
);

    localparam int CTL_W   = $bits(qopc_pkg::t_job_ctl);
    localparam int COORD_W = qopc_pkg::JOB_COORDS * (COORD_BITS + 1);
    localparam int JOB_W   = CTL_W + COORD_W;

    logic                                          w_accept, w_job_push, w_job_pop;
    logic                                          w_q_full, w_q_empty;
    qopc_pkg::t_job_ctl                            w_wr_ctl, w_rd_ctl;
    logic [qopc_pkg::JOB_COORDS-1:0][COORD_BITS:0] w_wr_coord, w_rd_coord;
    logic [JOB_W-1:0]                              w_rdata;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    qopc_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_accept(w_accept),
        .o_push  (w_job_push),
        .o_ctl   (w_wr_ctl),
        .o_coord (w_wr_coord)
    );

    qopc_fifo #(
        .WIDTH(JOB_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_job_push),
        .i_wdata({w_wr_ctl, w_wr_coord}),
        .i_pop  (w_job_pop),
        .o_rdata(w_rdata),
        .o_full (w_q_full),
        .o_empty(w_q_empty)
    );

    assign w_rd_ctl   = qopc_pkg::t_job_ctl'(w_rdata[JOB_W-1 -: CTL_W]);
    assign w_rd_coord = w_rdata[COORD_W-1:0];

    qopc_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job_valid(!w_q_empty),
        .i_ctl      (w_rd_ctl),
        .i_coord    (w_rd_coord),
        .o_job_pop  (w_job_pop),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_result   (o_result)
    );

    `QOPC_ASSERT_NOW(a_push_not_full, i_clk, i_rst_n, w_job_push, !w_q_full, "job pushed into full queue")
    `QOPC_ASSERT_NEXT(a_end_queues_job, i_clk, i_rst_n, w_accept && i_item.contour_end, !w_q_empty, "contour end left no job")
    `QOPC_ASSERT_NOW(a_end_is_last, i_clk, i_rst_n, !empty && o_result.command == qopc_pkg::CMD_END, o_result.last_of_run && o_result.first_x == '0 && o_result.end_x == '0, "end command malformed")

endmodule

// ===== src/qopc_fifo.sv =====
module qopc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = qopc_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DEPTH-1:0][WIDTH-1:0] r_mem;
    logic [PTR_W-1:0]            r_wr, r_rd, n_wr, n_rd;
    logic [CNT_W-1:0]            r_count, n_count;
    logic                        w_do_push, w_do_pop;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_do_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

endmodule

// ===== src/qopc_front.sv =====
module qopc_front #(
    parameter int COORD_BITS = qopc_pkg::COORD_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  qopc_pkg::t_in                                 i_item,
    input  logic                                          i_accept,
    output logic                                          o_push,
    output qopc_pkg::t_job_ctl                            o_ctl,
    output logic [qopc_pkg::JOB_COORDS-1:0][COORD_BITS:0] o_coord
);

    logic [qopc_pkg::WIDE_W-1:0] w_wide_x, w_wide_y;
    logic [COORD_BITS-1:0]       w_px, w_py, w_start_x, w_start_y;
    logic [COORD_BITS-1:0]       r_start_x, r_start_y, r_pend_x, r_pend_y;
    logic                        r_pend_valid, r_inside;
    logic                        w_pend_after;

    function automatic logic [COORD_BITS:0] dbl(input logic [COORD_BITS-1:0] p);
        return {p, 1'b0};
    endfunction

    function automatic logic [COORD_BITS:0] mid(input logic [COORD_BITS-1:0] a,
                                                input logic [COORD_BITS-1:0] b);
        return {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    endfunction

    // zero-extend the field, then keep the coordinate width
    assign w_wide_x  = qopc_pkg::WIDE_W'($unsigned(i_item.point_x));
    assign w_wide_y  = qopc_pkg::WIDE_W'($unsigned(i_item.point_y));
    assign w_px      = w_wide_x[COORD_BITS-1:0];
    assign w_py      = w_wide_y[COORD_BITS-1:0];
    assign w_start_x = r_inside ? r_start_x : w_px;
    assign w_start_y = r_inside ? r_start_y : w_py;

    always_comb begin
        o_ctl        = '0;
        o_ctl.prim_cmd = qopc_pkg::CMD_MOVE;
        o_coord      = '0;
        w_pend_after = 1'b0;
        if (!r_inside) begin
            o_ctl.has_prim            = 1'b1;
            o_ctl.prim_cmd            = qopc_pkg::CMD_MOVE;
            o_coord[qopc_pkg::J_AX]   = dbl(w_px);
            o_coord[qopc_pkg::J_AY]   = dbl(w_py);
        end else if (i_item.on_curve) begin
            o_ctl.has_prim = 1'b1;
            if (r_pend_valid) begin
                o_ctl.prim_cmd          = qopc_pkg::CMD_QUAD;
                o_coord[qopc_pkg::J_AX] = dbl(r_pend_x);
                o_coord[qopc_pkg::J_AY] = dbl(r_pend_y);
                o_coord[qopc_pkg::J_BX] = dbl(w_px);
                o_coord[qopc_pkg::J_BY] = dbl(w_py);
            end else begin
                o_ctl.prim_cmd          = qopc_pkg::CMD_LINE;
                o_coord[qopc_pkg::J_AX] = dbl(w_px);
                o_coord[qopc_pkg::J_AY] = dbl(w_py);
            end
        end else begin
            w_pend_after   = 1'b1;
            o_ctl.has_prim = r_pend_valid;
            o_ctl.prim_cmd = qopc_pkg::CMD_QUAD;
            o_coord[qopc_pkg::J_AX] = dbl(r_pend_x);
            o_coord[qopc_pkg::J_AY] = dbl(r_pend_y);
            o_coord[qopc_pkg::J_BX] = mid(r_pend_x, w_px);
            o_coord[qopc_pkg::J_BY] = mid(r_pend_y, w_py);
        end
        o_ctl.has_close         = i_item.contour_end;
        o_ctl.close_quad        = w_pend_after;
        o_coord[qopc_pkg::J_CX] = dbl(w_px);
        o_coord[qopc_pkg::J_CY] = dbl(w_py);
        o_coord[qopc_pkg::J_SX] = dbl(w_start_x);
        o_coord[qopc_pkg::J_SY] = dbl(w_start_y);
    end

    assign o_push = i_accept && (o_ctl.has_prim || i_item.contour_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_inside     <= 1'b0;
        end else if (i_accept) begin
            r_pend_valid <= w_pend_after && !i_item.contour_end;
            r_inside     <= !i_item.contour_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_start_x <= w_start_x;
            r_start_y <= w_start_y;
            if (r_inside && !i_item.on_curve) begin
                r_pend_x <= w_px;
                r_pend_y <= w_py;
            end
        end
    end

endmodule

// ===== src/qopc_back.sv =====
module qopc_back #(
    parameter int COORD_BITS = qopc_pkg::COORD_BITS
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_job_valid,
    input  qopc_pkg::t_job_ctl                            i_ctl,
    input  logic [qopc_pkg::JOB_COORDS-1:0][COORD_BITS:0] i_coord,
    output logic                                          o_job_pop,
    input  logic                                          i_pop,
    output logic                                          o_empty,
    output qopc_pkg::t_out                                o_result
);

    qopc_pkg::t_phase r_phase, w_cur, w_next;
    qopc_pkg::t_out   r_out, w_res;
    logic             r_out_valid;
    logic             w_out_ready, w_emit;

    // twice the raw value times eight gives signed 24.4
    function automatic logic [qopc_pkg::OUT_W-1:0] scale(input logic [COORD_BITS:0] d);
        logic [qopc_pkg::SCALE_W-1:0] e;
        e = qopc_pkg::SCALE_W'($signed(d));
        return {e[qopc_pkg::OUT_W-qopc_pkg::MID_SHIFT-1:0], {qopc_pkg::MID_SHIFT{1'b0}}};
    endfunction

    assign w_cur = (r_phase == qopc_pkg::PH_PRIM && !i_ctl.has_prim) ?
                   qopc_pkg::PH_CLOSE : r_phase;

    always_comb begin
        w_res  = '0;
        w_next = qopc_pkg::PH_PRIM;
        unique case (w_cur)
            qopc_pkg::PH_PRIM: begin
                w_res.command     = i_ctl.prim_cmd;
                w_res.first_x     = scale(i_coord[qopc_pkg::J_AX]);
                w_res.first_y     = scale(i_coord[qopc_pkg::J_AY]);
                if (i_ctl.prim_cmd == qopc_pkg::CMD_QUAD) begin
                    w_res.end_x = scale(i_coord[qopc_pkg::J_BX]);
                    w_res.end_y = scale(i_coord[qopc_pkg::J_BY]);
                end
                w_res.last_of_run = !i_ctl.has_close;
                w_next            = i_ctl.has_close ? qopc_pkg::PH_CLOSE : qopc_pkg::PH_PRIM;
            end
            qopc_pkg::PH_CLOSE: begin
                if (i_ctl.close_quad) begin
                    w_res.command = qopc_pkg::CMD_QUAD;
                    w_res.first_x = scale(i_coord[qopc_pkg::J_CX]);
                    w_res.first_y = scale(i_coord[qopc_pkg::J_CY]);
                    w_res.end_x   = scale(i_coord[qopc_pkg::J_SX]);
                    w_res.end_y   = scale(i_coord[qopc_pkg::J_SY]);
                end else begin
                    w_res.command = qopc_pkg::CMD_LINE;
                    w_res.first_x = scale(i_coord[qopc_pkg::J_SX]);
                    w_res.first_y = scale(i_coord[qopc_pkg::J_SY]);
                end
                w_next = qopc_pkg::PH_END;
            end
            qopc_pkg::PH_END: begin
                w_res.command     = qopc_pkg::CMD_END;
                w_res.last_of_run = 1'b1;
                w_next            = qopc_pkg::PH_PRIM;
            end
            default: begin
                w_next = qopc_pkg::PH_PRIM;
            end
        endcase
    end

    assign w_out_ready = !r_out_valid || i_pop;
    assign w_emit      = i_job_valid && w_out_ready;
    assign o_job_pop   = w_emit && w_res.last_of_run;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= qopc_pkg::PH_PRIM;
            r_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                r_phase <= w_next;
            end
            if (w_out_ready) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= w_res;
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int IN_W  = qopc_pkg::IN_W;
    localparam int OUT_W = qopc_pkg::OUT_W;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES = 8;
    localparam logic signed [IN_W-1:0] C_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] C_MIN = {1'b1, {(IN_W-1){1'b0}}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    qopc_pkg::t_in  i_item = '0;
    logic push = 1'b0;
    logic full;
    qopc_pkg::t_out o_result;
    logic empty;
    logic pop = 1'b0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    int errors = 0;
    int stall_cycles = 0;

    logic signed [IN_W-1:0] start_x = '0, start_y = '0;
    logic signed [IN_W-1:0] ctrl_x = '0, ctrl_y = '0;
    bit ctrl_held = 1'b0;
    bit in_contour = 1'b0;
    qopc_pkg::t_out cmds_due[$];

    quadratic_outline_to_path_commands DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .push     (push),
        .full     (full),
        .o_result (o_result),
        .empty    (empty),
        .pop      (pop)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic signed [OUT_W-1:0] to_fixed(logic signed [IN_W-1:0] v);
        return {v, 4'b0000};
    endfunction

    function automatic logic signed [OUT_W-1:0] mid_fixed(logic signed [IN_W-1:0] a,
                                                          logic signed [IN_W-1:0] b);
        logic signed [IN_W:0] s;
        s = {a[IN_W-1], a} + {b[IN_W-1], b};
        return {s, 3'b000};
    endfunction

    function automatic qopc_pkg::t_out path_cmd(qopc_pkg::t_cmd c,
                                                logic signed [OUT_W-1:0] fx,
                                                logic signed [OUT_W-1:0] fy,
                                                logic signed [OUT_W-1:0] ex,
                                                logic signed [OUT_W-1:0] ey);
        qopc_pkg::t_out r;
        r.command = c;
        r.first_x = fx;
        r.first_y = fy;
        r.end_x = ex;
        r.end_y = ey;
        r.last_of_run = 1'b0;
        return r;
    endfunction

    function automatic void outline_to_commands(qopc_pkg::t_in p);
        qopc_pkg::t_out r[3];
        int n;
        n = 0;
        if (!in_contour) begin
            start_x = p.point_x;
            start_y = p.point_y;
            ctrl_held = 1'b0;
            in_contour = 1'b1;
            r[n++] = path_cmd(qopc_pkg::CMD_MOVE, to_fixed(p.point_x), to_fixed(p.point_y),
                              '0, '0);
        end else if (p.on_curve) begin
            if (ctrl_held) begin
                r[n++] = path_cmd(qopc_pkg::CMD_QUAD, to_fixed(ctrl_x), to_fixed(ctrl_y),
                                  to_fixed(p.point_x), to_fixed(p.point_y));
                ctrl_held = 1'b0;
            end else begin
                r[n++] = path_cmd(qopc_pkg::CMD_LINE, to_fixed(p.point_x), to_fixed(p.point_y),
                                  '0, '0);
            end
        end else begin
            if (ctrl_held)
                r[n++] = path_cmd(qopc_pkg::CMD_QUAD, to_fixed(ctrl_x), to_fixed(ctrl_y),
                                  mid_fixed(ctrl_x, p.point_x), mid_fixed(ctrl_y, p.point_y));
            ctrl_x = p.point_x;
            ctrl_y = p.point_y;
            ctrl_held = 1'b1;
        end
        if (p.contour_end) begin
            if (ctrl_held)
                r[n++] = path_cmd(qopc_pkg::CMD_QUAD, to_fixed(ctrl_x), to_fixed(ctrl_y),
                                  to_fixed(start_x), to_fixed(start_y));
            else
                r[n++] = path_cmd(qopc_pkg::CMD_LINE, to_fixed(start_x), to_fixed(start_y),
                                  '0, '0);
            r[n++] = path_cmd(qopc_pkg::CMD_END, '0, '0, '0, '0);
            ctrl_held = 1'b0;
            in_contour = 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            r[i].last_of_run = (i == n - 1);
            cmds_due = {cmds_due, r[i]};
        end
    endfunction

    // entered and left just after a falling edge
    task automatic send_point(logic signed [IN_W-1:0] x, logic signed [IN_W-1:0] y,
                              bit on, bit last);
        qopc_pkg::t_in p;
        p.point_x = x;
        p.point_y = y;
        p.on_curve = on;
        p.contour_end = last;
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        i_item <= p;
        push <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        outline_to_commands(p);
        @(negedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return C_MAX;
            1: return C_MIN;
            2: return IN_W'($urandom_range(31));
            3: return -IN_W'($urandom_range(1, 32));
            default: return IN_W'($urandom);
        endcase
    endfunction

    task automatic send_contour(inout int count);
        int len;
        len = ($urandom_range(7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_point(pick_coord(), pick_coord(),
                       (i == 0) ? ($urandom_range(9) != 0) : 1'($urandom_range(1)),
                       i == len - 1);
        count += len;
    endtask

    task automatic test_directed_shapes();
        // lone off-curve point at the corners: move, line back, end
        send_point(C_MAX, C_MIN, 1'b0, 1'b1);
        send_point(C_MIN, C_MAX, 1'b1, 1'b1);
        // lines, held control, implied midpoint, three results at the close
        send_point(C_MIN, C_MIN, 1'b1, 1'b0);
        send_point(C_MAX, C_MAX, 1'b1, 1'b0);
        send_point(-24'sd1, 24'sd1, 1'b0, 1'b0);
        send_point(C_MAX, C_MIN, 1'b0, 1'b0);
        send_point('0, '0, 1'b1, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0, 1'b0);
        send_point(24'sd5, -24'sd7, 1'b0, 1'b1);
        // curve closed by an on-curve end point
        send_point(24'sd100, 24'sd200, 1'b1, 1'b0);
        send_point(24'sd300, -24'sd400, 1'b0, 1'b0);
        send_point(-24'sd3, 24'sd9, 1'b1, 1'b1);
        // midpoints at the extremes
        send_point('0, '0, 1'b1, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0, 1'b0);
        send_point(C_MAX, C_MAX, 1'b0, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0, 1'b0);
        send_point(C_MIN, C_MIN, 1'b0, 1'b0);
        send_point(C_MAX, C_MIN, 1'b1, 1'b0);
        // held control point closes with a curve to the start
        send_point(C_MIN, C_MAX, 1'b0, 1'b1);
        send_point(24'sd1, 24'sd1, 1'b1, 1'b0);
        send_point(24'sd2, 24'sd2, 1'b1, 1'b1);
    endtask

    task automatic test_contours(int n);
        int count;
        count = 0;
        while (count < n)
            send_contour(count);
    endtask

    task automatic test_flag_noise(int n);
        for (int i = 0; i < n; i++)
            send_point(IN_W'($urandom), IN_W'($urandom), 1'($urandom_range(1)),
                       $urandom_range(3) == 0);
    endtask

    task automatic test_full_stall(int n);
        int count;
        count = 0;
        push <= 1'b0;
        @(posedge i_clk);
        hold_request = 1'b1;
        @(negedge i_clk);
        while (count < n)
            send_contour(count);
    endtask

    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else begin
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin
        qopc_pkg::t_out want;
        if (i_rst_n && pop && !empty) begin
            if (cmds_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected transfer, expected nothing, actual %h",
                         $time, o_result);
            end else begin
                want = cmds_due.pop_front();
                if (o_result.command !== want.command)
                    report_field("command", 32'(want.command), 32'(o_result.command));
                if (o_result.first_x !== want.first_x)
                    report_field("first_x", 32'(want.first_x), 32'(o_result.first_x));
                if (o_result.first_y !== want.first_y)
                    report_field("first_y", 32'(want.first_y), 32'(o_result.first_y));
                if (o_result.end_x !== want.end_x)
                    report_field("end_x", 32'(want.end_x), 32'(o_result.end_x));
                if (o_result.end_y !== want.end_y)
                    report_field("end_y", 32'(want.end_y), 32'(o_result.end_y));
                if (o_result.last_of_run !== want.last_of_run)
                    report_field("last_of_run", 32'(want.last_of_run),
                                 32'(o_result.last_of_run));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("quadratic_outline_to_path_commands verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 30;
        recv_idle_pct = 67;
        test_directed_shapes();
        test_contours(130);

        send_idle_pct = 67;
        recv_idle_pct = 30;
        test_contours(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_flag_noise(80);
        test_full_stall(50);

        push <= 1'b0;
        while (cmds_due.size() != 0)
            @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);

        if (errors == 0 && cmds_due.size() == 0)
            $display("quadratic_outline_to_path_commands verification clean");
        else
            $display("quadratic_outline_to_path_commands verification failed");
        $finish;
    end

endmodule
